FILE: hdl/ssq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssq_pkg
// shared types and constants of the sensor sample qualifier
// ----------------------------------------------------------------------------
package ssq_pkg;

  localparam int unsigned ChannelCountDefault = 32;
  localparam int unsigned SilenceMarkDefault  = 32768;
  localparam int unsigned SampleW  = 16;
  localparam int unsigned ThreshW  = 15;
  localparam int unsigned CountW   = 8;
  localparam int unsigned WinW     = 11;
  localparam int unsigned AccW     = 32;
  localparam int unsigned ChanW    = 5;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 11;

  localparam logic [CfgIdxW-1:0] CfgWindow  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgAlarm   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgCut     = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSilence = 2'd3;

  localparam logic ActSample = 1'b0;
  localparam logic ActLoad   = 1'b1;

  typedef struct packed {
    logic                action;
    logic [ChanW-1:0]    channel;
    logic [SampleW-1:0]  sample;
    logic [SampleW-1:0]  departing_sample;
    logic [ThreshW-1:0]  alarm_high_in;
    logic [ThreshW-1:0]  alarm_low_in;
    logic [ThreshW-1:0]  cut_high_in;
    logic [ThreshW-1:0]  cut_low_in;
  } in_item_t;

  typedef struct packed {
    logic [SampleW-1:0] value_out;
    logic [SampleW-1:0] average_out;
    logic [SampleW-1:0] peak_high;
    logic [SampleW-1:0] peak_low;
    logic               alarm_sticky;
    logic               cut_sticky;
    logic               silence_flag;
  } out_item_t;

  typedef struct packed {
    logic [WinW-1:0]   window_length;
    logic [CountW-1:0] alarm_limit;
    logic [CountW-1:0] cut_limit;
    logic [CountW-1:0] silence_limit;
  } cfg_t;

endpackage

FILE: hdl/ssq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssq_in_if / ssq_out_if
// valid/ready channels carrying input and result transactions
// ----------------------------------------------------------------------------
interface ssq_in_if import ssq_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface ssq_out_if import ssq_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: hdl/ssq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssq_front
// two-entry queue between the input channel and the processing engine
// ----------------------------------------------------------------------------
module ssq_front import ssq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_item_i,
  output logic     q_valid_o,
  input  logic     q_pop_i,
  output in_item_t q_item_o
);
  in_item_t  mem_q [2];
  logic      wr_q, rd_q;
  logic [1:0] cnt_q;
  logic push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push = in_valid_i && in_ready_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign pop = q_pop_i && q_valid_o;
  assign q_item_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

FILE: hdl/ssq_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssq_div
// restoring divider, 32-bit dividend by 11-bit divisor, one bit per cycle
// ----------------------------------------------------------------------------
module ssq_div import ssq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [AccW-1:0]   dividend_i,
  input  logic [WinW-1:0]   divisor_i,
  output logic              done_o,
  output logic [AccW-1:0]   quotient_o
);
  logic [AccW-1:0] quo_q, quo_d;
  logic [WinW:0]   rem_q, rem_d;
  logic [WinW-1:0] dvs_q;
  logic [5:0]      cnt_q;
  logic            busy_q;
  logic [WinW:0]   trial;

  assign trial = {rem_q[WinW-1:0], quo_q[AccW-1]};
  always_comb begin
    rem_d = trial;
    quo_d = {quo_q[AccW-2:0], 1'b0};
    if (trial >= {1'b0, dvs_q}) begin
      rem_d = trial - {1'b0, dvs_q};
      quo_d[0] = 1'b1;
    end
  end

  assign quotient_o = quo_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(AccW - 1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: hdl/ssq_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssq_back
// per-channel state, band checks, average update and result register
// ----------------------------------------------------------------------------
module ssq_back import ssq_pkg::*; #(
  parameter int unsigned CHANNEL_COUNT = ChannelCountDefault,
  parameter int unsigned SILENCE_MARK  = SilenceMarkDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      q_valid_i,
  output logic      q_pop_o,
  input  in_item_t  q_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);
  localparam int unsigned IdxW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam logic [SampleW-1:0] Mark = SampleW'(SILENCE_MARK);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRead = 3'd1;
  localparam logic [2:0] StMul  = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  // status word layout: avg, peak hi, peak lo, counts a/c/s, flags
  localparam int unsigned StW = 3 * SampleW + 3 * CountW + 3;

  logic [StW-1:0]  st_mem [CHANNEL_COUNT];
  logic [4*ThreshW-1:0] th_mem [CHANNEL_COUNT];
  logic [CHANNEL_COUNT-1:0] vld_q;

  logic [2:0] state_q;
  in_item_t   it_q;
  logic [StW-1:0] st_rd_q;
  logic [4*ThreshW-1:0] th_rd_q;
  logic [AccW-1:0] acc;
  logic [WinW-1:0] w_sel;
  logic [IdxW-1:0] idx;
  logic in_range;
  logic div_start, div_done;
  logic [AccW-1:0] quo;
  logic [StW-1:0] st_cur, st_new;
  logic wr_en;

  logic [SampleW-1:0] avg, phi, plo, avg_n, phi_n, plo_n, value, dep;
  logic [CountW-1:0] ca, cc, cs, ca_n, cc_n, cs_n;
  logic [2:0] fl, fl_n;
  logic [ThreshW-1:0] ah, al, ch, cl;
  logic silent, viol_a, viol_c;
  out_item_t res_d, res_q;

  assign idx = IdxW'(it_q.channel);
  assign in_range = ({27'd0, it_q.channel} < 32'(CHANNEL_COUNT));
  assign q_pop_o = (state_q == StIdle) && q_valid_i;

  assign st_cur = vld_q[idx] ? st_rd_q : {{(2*SampleW){1'b0}}, {SampleW{1'b1}},
                                          {(3*CountW+3){1'b0}}};
  assign {avg, phi, plo, ca, cc, cs, fl} = st_cur;
  assign {ah, al, ch, cl} = th_rd_q;

  assign silent = (it_q.sample >= Mark);
  assign value  = silent ? avg : it_q.sample;
  assign dep    = it_q.departing_sample & ~Mark;
  assign viol_a = ({1'b0, it_q.sample[ThreshW-1:0]} >= {1'b0, ah}) ||
                  (it_q.sample <= {1'b0, al});
  assign viol_c = ({1'b0, it_q.sample[ThreshW-1:0]} >= {1'b0, ch}) ||
                  (it_q.sample <= {1'b0, cl});

  assign w_sel = (cfg_i.window_length == '0) ? WinW'(1) : cfg_i.window_length;
  assign acc   = AccW'({16'd0, avg} * {21'd0, w_sel}) - {16'd0, dep} + {16'd0, value};

  always_comb begin
    ca_n = ca; cc_n = cc; cs_n = cs; fl_n = fl;
    if (silent) begin
      cs_n = (cs == 8'hFF) ? cs : cs + 8'd1;
      if (cs_n >= cfg_i.silence_limit) fl_n[2] = 1'b1;
    end else begin
      cs_n = (cs == 8'd0) ? cs : cs - 8'd1;
      if (viol_a) begin
        ca_n = (ca == 8'hFF) ? ca : ca + 8'd1;
        if (ca_n >= cfg_i.alarm_limit) fl_n[0] = 1'b1;
      end else begin
        ca_n = (ca == 8'd0) ? ca : ca - 8'd1;
      end
      if (viol_c) begin
        cc_n = (cc == 8'hFF) ? cc : cc + 8'd1;
        if (cc_n >= cfg_i.cut_limit) fl_n[1] = 1'b1;
      end else begin
        cc_n = (cc == 8'd0) ? cc : cc - 8'd1;
      end
    end
    avg_n = quo[SampleW-1:0];
    phi_n = (avg_n > phi) ? avg_n : phi;
    plo_n = (avg_n < plo) ? avg_n : plo;
  end

  assign st_new = {avg_n, phi_n, plo_n, ca_n, cc_n, cs_n, fl_n};
  assign div_start = (state_q == StMul);
  assign wr_en = (state_q == StDiv) && div_done;

  ssq_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc),
    .divisor_i  (w_sel),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  always_comb begin
    res_d = '0;
    if (in_range) begin
      if (it_q.action == ActLoad) begin
        res_d.peak_low = {SampleW{1'b1}};
      end else begin
        res_d.value_out    = silent ? (avg | Mark) : it_q.sample;
        res_d.average_out  = avg_n;
        res_d.peak_high    = phi_n;
        res_d.peak_low     = plo_n;
        res_d.alarm_sticky = fl_n[0];
        res_d.cut_sticky   = fl_n[1];
        res_d.silence_flag = fl_n[2];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) it_q <= q_item_i;
    if (state_q == StRead) begin
      st_rd_q <= st_mem[idx];
      th_rd_q <= th_mem[idx];
    end
    if (state_q == StRead && in_range && it_q.action == ActLoad) begin
      th_mem[idx] <= {it_q.alarm_high_in, it_q.alarm_low_in,
                      it_q.cut_high_in, it_q.cut_low_in};
    end
    if (wr_en && in_range) st_mem[idx] <= st_new;
    if ((wr_en) || (state_q == StMul && (it_q.action == ActLoad || !in_range)))
      res_q <= res_d;
    if (state_q == StOut && !out_valid_o) out_item_o <= res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      vld_q <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      case (state_q)
        StIdle: if (q_pop_o) state_q <= StRead;
        StRead: state_q <= StMul;
        StMul: begin
          if (it_q.action == ActLoad || !in_range) begin
            if (it_q.action == ActLoad && in_range) vld_q[idx] <= 1'b0;
            state_q <= StOut;
          end else begin
            state_q <= StDiv;
          end
        end
        StDiv: if (div_done) begin
          if (in_range) vld_q[idx] <= 1'b1;
          state_q <= StOut;
        end
        StOut: if (!out_valid_o) begin
          out_valid_o <= 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

FILE: hdl/sensor_sample_qualifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_sample_qualifier
// per-channel sample qualifier with band checks and running average
// ----------------------------------------------------------------------------
// in_if carries one transaction per sample or threshold load; out_if returns
// exactly one result transaction for each, in order.
// cfg_we_i writes register cfg_idx_i (0 window, 1 alarm limit, 2 cut limit,
// 3 silence limit) with cfg_data_i; write only while the block is idle.
// a sample passes through state read, multiply, then a one-bit-per-cycle
// 32-step divide by the window length before its result is registered.
// a load or an out-of-range channel skips the divide.
// a two-entry input queue keeps accepting while the engine works.
// reset empties the queue and the result register and marks every channel
// as cleared; thresholds must be loaded before a channel is sampled.
// when the receiver stalls, the result holds and the engine waits, the queue
// then fills and in_if.ready drops.
// ----------------------------------------------------------------------------
module sensor_sample_qualifier import ssq_pkg::*; #(
  parameter int unsigned CHANNEL_COUNT = ChannelCountDefault,
  parameter int unsigned SILENCE_MARK  = SilenceMarkDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  ssq_in_if.sink              in_if,
  ssq_out_if.source           out_if,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);
  cfg_t     cfg_q;
  logic     q_valid, q_pop;
  in_item_t q_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_length <= WinW'(16);
      cfg_q.alarm_limit   <= CountW'(3);
      cfg_q.cut_limit     <= CountW'(3);
      cfg_q.silence_limit <= CountW'(3);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgWindow:  cfg_q.window_length <= cfg_data_i;
        CfgAlarm:   cfg_q.alarm_limit   <= cfg_data_i[CountW-1:0];
        CfgCut:     cfg_q.cut_limit     <= cfg_data_i[CountW-1:0];
        CfgSilence: cfg_q.silence_limit <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  ssq_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .in_item_i  (in_if.payload),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_item_o   (q_item)
  );

  ssq_back #(
    .CHANNEL_COUNT (CHANNEL_COUNT),
    .SILENCE_MARK  (SILENCE_MARK)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_item_i    (q_item),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_item_o  (out_if.payload)
  );
endmodule

FILE: hdl/ssq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssq_checker
// port-level checks of the sensor sample qualifier
// ----------------------------------------------------------------------------
module ssq_checker import ssq_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  a_peak_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_item.silence_flag == 1'b0 && out_item.peak_high != 16'd0
    |-> out_item.peak_low <= out_item.peak_high)
    else $error("peak low above peak high");

  a_no_back2back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready |=> !out_valid)
    else $error("results closer than engine allows");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid)
    else $error("result valid in reset");
endmodule

bind sensor_sample_qualifier ssq_checker u_ssq_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_item  (out_if.payload)
);
